FILE: rtl/core/gcs_pkg.sv
// Shared types, constants and helper functions of the gradient color sampler.
package gcs_pkg;

   localparam int MAX_STOPS     = 16;
   localparam int POSITION_BITS = 16;
   localparam int STOP_IDX_W    = $clog2(MAX_STOPS);
   localparam int CSR_W         = 5;
   localparam int CH_W          = 8;
   localparam int NUM_CH        = 4;
   localparam int PROD_W        = POSITION_BITS + CH_W;
   localparam int NUM_W         = POSITION_BITS + CH_W + 1;
   localparam int QSTEPS        = CH_W;
   localparam int STEP_W        = $clog2(QSTEPS);

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [CH_W-1:0]          chan_type;
   typedef chan_type [NUM_CH-1:0]    color_type;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  stop_slot;
      logic [15:0] stop_position;
      logic [7:0]  stop_red;
      logic [7:0]  stop_green;
      logic [7:0]  stop_blue;
      logic [7:0]  stop_alpha;
      logic [15:0] sample_position;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   typedef struct packed {
      pos_type  pos;
      chan_type red;
      chan_type green;
      chan_type blue;
      chan_type alpha;
   } stop_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHK0,
      S_CHKL,
      S_SCAN,
      S_MUL,
      S_SUM,
      S_DIV
   } state_type;

   typedef enum logic [1:0] {
      OSEL_WHITE,
      OSEL_ENTRY,
      OSEL_QUOT
   } out_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        load_left;
      logic        load_pair;
      logic        mul;
      logic        sum;
      logic        div_step;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic at_or_below;
      logic at_or_above;
      logic bracket;
      logic zero_span;
   } stat_type;

   function automatic color_type stop_colors(input stop_type e);
      color_type c;
      c[0] = e.red;
      c[1] = e.green;
      c[2] = e.blue;
      c[3] = e.alpha;
      return c;
   endfunction

   function automatic rsp_type to_rsp(input color_type c);
      rsp_type r;
      r.out_red   = c[0];
      r.out_green = c[1];
      r.out_blue  = c[2];
      r.out_alpha = c[3];
      return r;
   endfunction

endpackage

FILE: rtl/core/gcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/gcs_ctrl.sv
// Controller of the gradient color sampler: handshake, stop search and divide sequencing.
module gcs_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_opcode,
   input  logic [3:0]                     req_slot,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gcs_pkg::CSR_W-1:0]      csr_data,
   input  gcs_pkg::stat_type              stat,
   output gcs_pkg::cmd_type               cmd,
   output logic                           ram_wr_en,
   output logic [gcs_pkg::STOP_IDX_W-1:0] ram_rd_addr
);
   import gcs_pkg::*;

   state_type             state_ff, state_in;
   logic [CSR_W-1:0]      count_ff, count_in;
   logic [STOP_IDX_W-1:0] last_ff, last_in;
   logic [STOP_IDX_W-1:0] idx_ff, idx_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  accept;
   logic                  sample;
   logic                  empty;
   logic                  at_last;
   logic                  last_step;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign sample    = (req_opcode == OP_SAMPLE);
   assign empty     = (count_ff == '0);
   assign at_last   = (idx_ff == last_ff);
   assign last_step = (step_ff == STEP_W'(QSTEPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && sample && !empty) begin
               state_in = S_CHK0;
            end
         end
         S_CHK0: begin
            if (!stat.at_or_below) begin
               state_in = S_CHKL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CHKL: begin
            if (!stat.at_or_above) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (stat.bracket && !stat.zero_span) begin
               state_in = S_MUL;
            end else if (stat.bracket || at_last) begin
               state_in = S_IDLE;
            end
         end
         S_MUL: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (last_step) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.out_sel = OSEL_ENTRY;
      ram_wr_en   = 1'b0;
      ram_rd_addr = '0;
      last_in     = last_ff;
      idx_in      = idx_ff;
      step_in     = step_ff;
      count_in    = csr_valid ? csr_data : count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && sample) begin
               cmd.load_req = 1'b1;
               if (empty) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = OSEL_WHITE;
               end
               if (32'(count_ff) > MAX_STOPS) begin
                  last_in = STOP_IDX_W'(MAX_STOPS - 1);
               end else begin
                  last_in = STOP_IDX_W'(count_ff - CSR_W'(1));
               end
            end else if (accept) begin
               ram_wr_en = (32'(req_slot) < MAX_STOPS);
            end
         end
         S_CHK0: begin
            cmd.load_left = 1'b1;
            ram_rd_addr   = last_ff;
            cmd.out_load  = stat.at_or_below;
         end
         S_CHKL: begin
            ram_rd_addr  = STOP_IDX_W'(1);
            idx_in       = STOP_IDX_W'(1);
            cmd.out_load = stat.at_or_above;
         end
         S_SCAN: begin
            if (stat.bracket) begin
               cmd.load_pair = 1'b1;
               cmd.out_load  = stat.zero_span;
            end else if (at_last) begin
               cmd.out_load = 1'b1;
            end else begin
               cmd.load_left = 1'b1;
               ram_rd_addr   = idx_ff + STOP_IDX_W'(1);
               idx_in        = idx_ff + STOP_IDX_W'(1);
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
         end
         S_SUM: begin
            cmd.sum = 1'b1;
            step_in = '0;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (last_step) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OSEL_QUOT;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      last_ff <= last_in;
      idx_ff  <= idx_in;
      step_ff <= step_in;
   end

endmodule

FILE: rtl/core/gcs_datapath.sv
// Datapath of the gradient color sampler: compares, channel products and restoring dividers.
module gcs_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  gcs_pkg::req_type               req,
   input  gcs_pkg::cmd_type               cmd,
   output gcs_pkg::stat_type              stat,
   input  gcs_pkg::stop_type              ram_rd_data,
   output logic [gcs_pkg::STOP_IDX_W-1:0] ram_wr_addr,
   output gcs_pkg::stop_type              ram_wr_data,
   output logic                           rsp_valid,
   output gcs_pkg::rsp_type               rsp
);
   import gcs_pkg::*;

   pos_type                pos_ff, pos_in;
   stop_type               left_ff, left_in;
   color_type              rcol_ff, rcol_in;
   pos_type                dr_ff, dr_in;
   pos_type                dl_ff, dl_in;
   pos_type                span_ff, span_in;
   logic [NUM_W-1:0]       dvs_ff, dvs_in;
   logic [PROD_W-1:0]      pa_ff [NUM_CH];
   logic [PROD_W-1:0]      pa_in [NUM_CH];
   logic [PROD_W-1:0]      pb_ff [NUM_CH];
   logic [PROD_W-1:0]      pb_in [NUM_CH];
   logic [NUM_W-1:0]       rem_ff [NUM_CH];
   logic [NUM_W-1:0]       rem_in [NUM_CH];
   color_type              quo_ff, quo_in;
   rsp_type                out_ff, out_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   color_type              lcol;
   color_type              ecol;
   logic                   fits;

   assign ram_wr_addr = STOP_IDX_W'(req.stop_slot);
   always_comb begin
      ram_wr_data.pos   = POSITION_BITS'(req.stop_position);
      ram_wr_data.red   = req.stop_red;
      ram_wr_data.green = req.stop_green;
      ram_wr_data.blue  = req.stop_blue;
      ram_wr_data.alpha = req.stop_alpha;
   end

   assign lcol = stop_colors(left_ff);
   assign ecol = stop_colors(ram_rd_data);

   assign stat.at_or_below = (pos_ff <= ram_rd_data.pos);
   assign stat.at_or_above = (pos_ff >= ram_rd_data.pos);
   assign stat.bracket     = (pos_ff >= left_ff.pos) && (pos_ff <= ram_rd_data.pos);
   assign stat.zero_span   = (ram_rd_data.pos <= left_ff.pos);

   always_comb begin
      pos_in  = cmd.load_req ? POSITION_BITS'(req.sample_position) : pos_ff;
      left_in = cmd.load_left ? ram_rd_data : left_ff;
      rcol_in = rcol_ff;
      dr_in   = dr_ff;
      dl_in   = dl_ff;
      span_in = span_ff;
      dvs_in  = dvs_ff;
      fits    = 1'b0;
      quo_in  = quo_ff;
      if (cmd.load_pair) begin
         rcol_in = ecol;
         dr_in   = ram_rd_data.pos - pos_ff;
         dl_in   = pos_ff - left_ff.pos;
         span_in = ram_rd_data.pos - left_ff.pos;
         dvs_in  = NUM_W'(ram_rd_data.pos - left_ff.pos) << CH_W;
      end else if (cmd.div_step) begin
         dvs_in = dvs_ff >> 1;
      end
      for (int c = 0; c < NUM_CH; c++) begin
         pa_in[c]  = pa_ff[c];
         pb_in[c]  = pb_ff[c];
         rem_in[c] = rem_ff[c];
         if (cmd.mul) begin
            pa_in[c] = PROD_W'(lcol[c]) * PROD_W'(dr_ff);
            pb_in[c] = PROD_W'(rcol_ff[c]) * PROD_W'(dl_ff);
         end
         if (cmd.sum) begin
            rem_in[c] = {1'b0, pa_ff[c]} + {1'b0, pb_ff[c]};
            rem_in[c] = (rem_in[c] << 1) + NUM_W'(span_ff);
         end
         if (cmd.div_step) begin
            fits      = (rem_ff[c] >= dvs_ff);
            rem_in[c] = fits ? (rem_ff[c] - dvs_ff) : rem_ff[c];
            quo_in[c] = {quo_ff[c][CH_W-2:0], fits};
         end
      end
   end

   always_comb begin
      out_in       = out_ff;
      rsp_valid_in = cmd.out_load;
      if (cmd.out_load) begin
         case (cmd.out_sel)
            OSEL_WHITE: out_in = '1;
            OSEL_QUOT:  out_in = to_rsp(quo_in);
            default:    out_in = to_rsp(ecol);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff  <= pos_in;
      left_ff <= left_in;
      rcol_ff <= rcol_in;
      dr_ff   <= dr_in;
      dl_ff   <= dl_in;
      span_ff <= span_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
      out_ff  <= out_in;
      for (int c = 0; c < NUM_CH; c++) begin
         pa_ff[c]  <= pa_in[c];
         pb_ff[c]  <= pb_in[c];
         rem_ff[c] <= rem_in[c];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = out_ff;

endmodule

FILE: rtl/core/gradient_color_sampler.sv
// Top level of the gradient color sampler: stop table, controller and datapath.
//
// The request channel takes one word when start is high and busy is low.
// A word with opcode write stores one stop (position and RGBA color) in the
// slot it names and gives no result.
// A word with opcode sample returns one color on rsp, marked by rsp_valid for
// exactly one cycle; the receiver cannot hold it off.
// An empty table gives its white result in the cycle after the request.
// A position at or below the first stop, or at or above the last, gives the
// color of that stop as its result.
// Otherwise the stops are scanned one per cycle from the stop table memory,
// and the four channels are interpolated in parallel lanes by a product
// step, a sum step and one restoring divide step per bit of the eight-bit
// quotient. At most 15 stops are scanned; a zero-span or unbracketed
// search gives the color of the stop it ends on instead.
// Busy stays high until the result is loaded, so the next request may come
// in the cycle in which rsp_valid is high.
// The csr channel writes stops_in_use and is always ready. Reset clears the
// controller and stops_in_use; the stop table must be written before use.
module gradient_color_sampler (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  gcs_pkg::req_type          req,
   output logic                      rsp_valid,
   output gcs_pkg::rsp_type          rsp,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [gcs_pkg::CSR_W-1:0] csr_data
);
   import gcs_pkg::*;

   cmd_type               cmd;
   stat_type              stat;
   logic                  ram_wr_en;
   logic [STOP_IDX_W-1:0] ram_wr_addr;
   logic [STOP_IDX_W-1:0] ram_rd_addr;
   stop_type              ram_wr_data;
   stop_type              ram_rd_data;

   gcs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_opcode  (req.opcode),
      .req_slot    (req.stop_slot),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .stat        (stat),
      .cmd         (cmd),
      .ram_wr_en   (ram_wr_en),
      .ram_rd_addr (ram_rd_addr)
   );

   gcs_ram #(
      .WIDTH ($bits(stop_type)),
      .DEPTH (MAX_STOPS)
   ) u_stop_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   gcs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .cmd         (cmd),
      .stat        (stat),
      .ram_rd_data (ram_rd_data),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

endmodule
